@@ design/ppp_neg_pkg.sv @@
// Shared types, action codes and the transition table of the PPP option negotiation automaton.
package ppp_neg_pkg;

    localparam int NUM_STATES = 10;
    localparam int NUM_EVENTS = 16;
    localparam int ACT_W      = 13;

    // Automaton states
    typedef enum logic [3:0] {
        ST_INITIAL  = 4'd0,
        ST_STARTING = 4'd1,
        ST_CLOSED   = 4'd2,
        ST_STOPPED  = 4'd3,
        ST_CLOSING  = 4'd4,
        ST_STOPPING = 4'd5,
        ST_REQ_SENT = 4'd6,
        ST_ACK_RCVD = 4'd7,
        ST_ACK_SENT = 4'd8,
        ST_OPENED   = 4'd9
    } state_t;

    // Events, all sixteen codes are used
    typedef enum logic [3:0] {
        EV_UP     = 4'd0,
        EV_DOWN   = 4'd1,
        EV_OPEN   = 4'd2,
        EV_CLOSE  = 4'd3,
        EV_TO_P   = 4'd4,
        EV_TO_M   = 4'd5,
        EV_RCR_P  = 4'd6,
        EV_RCR_M  = 4'd7,
        EV_RCA    = 4'd8,
        EV_RCN    = 4'd9,
        EV_RTR    = 4'd10,
        EV_RTA    = 4'd11,
        EV_RUC    = 4'd12,
        EV_RXJ_P  = 4'd13,
        EV_RXJ_M  = 4'd14,
        EV_RXR    = 4'd15
    } event_t;

    // Layer kinds
    localparam logic LAYER_LCP = 1'b0;
    localparam logic LAYER_NCP = 1'b1;

    // Action mask bits
    localparam logic [ACT_W-1:0] ACT_NONE = 13'h0000;
    localparam logic [ACT_W-1:0] ACT_TLU  = 13'h0001;
    localparam logic [ACT_W-1:0] ACT_TLD  = 13'h0002;
    localparam logic [ACT_W-1:0] ACT_TLS  = 13'h0004;
    localparam logic [ACT_W-1:0] ACT_TLF  = 13'h0008;
    localparam logic [ACT_W-1:0] ACT_IRC  = 13'h0010;
    localparam logic [ACT_W-1:0] ACT_ZRC  = 13'h0020;
    localparam logic [ACT_W-1:0] ACT_SCR  = 13'h0040;
    localparam logic [ACT_W-1:0] ACT_SCA  = 13'h0080;
    localparam logic [ACT_W-1:0] ACT_SCN  = 13'h0100;
    localparam logic [ACT_W-1:0] ACT_STR  = 13'h0200;
    localparam logic [ACT_W-1:0] ACT_STA  = 13'h0400;
    localparam logic [ACT_W-1:0] ACT_SCJ  = 13'h0800;
    localparam logic [ACT_W-1:0] ACT_SER  = 13'h1000;

    // One table entry
    typedef struct packed {
        logic             legal;
        state_t           next_state;
        logic [ACT_W-1:0] actions;
    } entry_t;

    // Result of one lookup, passed from the lookup logic to the top level
    typedef struct packed {
        state_t           next_state;
        logic [ACT_W-1:0] action_mask;
        logic             illegal;
    } lookup_t;

    function automatic entry_t ent(state_t ns, logic [ACT_W-1:0] acts);
        entry_t e;
        e.legal      = 1'b1;
        e.next_state = ns;
        e.actions    = acts;
        return e;
    endfunction

    localparam entry_t NOPE = '0;

    // Transition table, rows by state, columns by event
    localparam entry_t FSM_TABLE [0:NUM_STATES-1][0:NUM_EVENTS-1] = '{
        // initial
        '{ent(ST_CLOSED, ACT_NONE), NOPE, ent(ST_STARTING, ACT_TLS),
          ent(ST_INITIAL, ACT_NONE), NOPE, NOPE, NOPE, NOPE,
          NOPE, NOPE, NOPE, NOPE, NOPE, NOPE, NOPE, NOPE},
        // starting
        '{ent(ST_REQ_SENT, ACT_IRC | ACT_SCR), NOPE, ent(ST_STARTING, ACT_NONE),
          ent(ST_INITIAL, ACT_TLF), NOPE, NOPE, NOPE, NOPE,
          NOPE, NOPE, NOPE, NOPE, NOPE, NOPE, NOPE, NOPE},
        // closed
        '{NOPE, ent(ST_INITIAL, ACT_NONE), ent(ST_REQ_SENT, ACT_IRC | ACT_SCR),
          ent(ST_CLOSED, ACT_NONE), NOPE, NOPE,
          ent(ST_CLOSED, ACT_STA), ent(ST_CLOSED, ACT_STA), ent(ST_CLOSED, ACT_STA),
          ent(ST_CLOSED, ACT_STA), ent(ST_CLOSED, ACT_STA), ent(ST_CLOSED, ACT_NONE),
          ent(ST_CLOSED, ACT_SCJ), ent(ST_CLOSED, ACT_NONE), ent(ST_CLOSED, ACT_TLF),
          ent(ST_CLOSED, ACT_NONE)},
        // stopped
        '{NOPE, ent(ST_STARTING, ACT_TLS), ent(ST_STOPPED, ACT_NONE),
          ent(ST_CLOSED, ACT_NONE), NOPE, NOPE,
          ent(ST_ACK_SENT, ACT_IRC | ACT_SCR | ACT_SCA),
          ent(ST_REQ_SENT, ACT_IRC | ACT_SCR | ACT_SCN),
          ent(ST_STOPPED, ACT_STA), ent(ST_STOPPED, ACT_STA), ent(ST_STOPPED, ACT_STA),
          ent(ST_STOPPED, ACT_NONE), ent(ST_STOPPED, ACT_SCJ), ent(ST_STOPPED, ACT_NONE),
          ent(ST_STOPPED, ACT_TLF), ent(ST_STOPPED, ACT_NONE)},
        // closing
        '{NOPE, ent(ST_INITIAL, ACT_NONE), ent(ST_STOPPING, ACT_NONE),
          ent(ST_CLOSING, ACT_NONE), ent(ST_CLOSING, ACT_STR), ent(ST_CLOSED, ACT_TLF),
          ent(ST_CLOSING, ACT_NONE), ent(ST_CLOSING, ACT_NONE), ent(ST_CLOSING, ACT_NONE),
          ent(ST_CLOSING, ACT_NONE), ent(ST_CLOSING, ACT_STA), ent(ST_CLOSED, ACT_TLF),
          ent(ST_CLOSING, ACT_SCJ), ent(ST_CLOSING, ACT_NONE), ent(ST_CLOSED, ACT_TLF),
          ent(ST_CLOSING, ACT_NONE)},
        // stopping
        '{NOPE, ent(ST_STARTING, ACT_NONE), ent(ST_STOPPING, ACT_NONE),
          ent(ST_CLOSING, ACT_NONE), ent(ST_STOPPING, ACT_STR), ent(ST_STOPPED, ACT_TLF),
          ent(ST_STOPPING, ACT_NONE), ent(ST_STOPPING, ACT_NONE),
          ent(ST_STOPPING, ACT_NONE), ent(ST_STOPPING, ACT_NONE),
          ent(ST_STOPPING, ACT_STA), ent(ST_STOPPED, ACT_TLF),
          ent(ST_STOPPING, ACT_SCJ), ent(ST_STOPPING, ACT_NONE),
          ent(ST_STOPPED, ACT_TLF), ent(ST_STOPPING, ACT_NONE)},
        // req-sent
        '{NOPE, ent(ST_STARTING, ACT_NONE), ent(ST_REQ_SENT, ACT_NONE),
          ent(ST_CLOSING, ACT_IRC | ACT_STR), ent(ST_REQ_SENT, ACT_SCR),
          ent(ST_STOPPED, ACT_TLF), ent(ST_ACK_SENT, ACT_SCA), ent(ST_REQ_SENT, ACT_SCN),
          ent(ST_ACK_RCVD, ACT_IRC), ent(ST_REQ_SENT, ACT_IRC | ACT_SCR),
          ent(ST_REQ_SENT, ACT_STA), ent(ST_REQ_SENT, ACT_NONE),
          ent(ST_REQ_SENT, ACT_SCJ), ent(ST_REQ_SENT, ACT_NONE),
          ent(ST_STOPPED, ACT_TLF), ent(ST_REQ_SENT, ACT_NONE)},
        // ack-rcvd
        '{NOPE, ent(ST_STARTING, ACT_NONE), ent(ST_ACK_RCVD, ACT_NONE),
          ent(ST_CLOSING, ACT_IRC | ACT_STR), ent(ST_REQ_SENT, ACT_SCR),
          ent(ST_STOPPED, ACT_TLF), ent(ST_OPENED, ACT_SCA | ACT_TLU),
          ent(ST_ACK_RCVD, ACT_SCN), ent(ST_REQ_SENT, ACT_SCR), ent(ST_REQ_SENT, ACT_SCR),
          ent(ST_REQ_SENT, ACT_STA), ent(ST_REQ_SENT, ACT_NONE),
          ent(ST_ACK_RCVD, ACT_SCJ), ent(ST_REQ_SENT, ACT_NONE),
          ent(ST_STOPPED, ACT_TLF), ent(ST_ACK_RCVD, ACT_NONE)},
        // ack-sent
        '{NOPE, ent(ST_STARTING, ACT_NONE), ent(ST_ACK_SENT, ACT_NONE),
          ent(ST_CLOSING, ACT_IRC | ACT_STR), ent(ST_ACK_SENT, ACT_SCR),
          ent(ST_STOPPED, ACT_TLF), ent(ST_ACK_SENT, ACT_SCA), ent(ST_REQ_SENT, ACT_SCN),
          ent(ST_OPENED, ACT_IRC | ACT_TLU), ent(ST_ACK_SENT, ACT_IRC | ACT_SCR),
          ent(ST_REQ_SENT, ACT_STA), ent(ST_ACK_SENT, ACT_NONE),
          ent(ST_ACK_SENT, ACT_SCJ), ent(ST_ACK_SENT, ACT_NONE),
          ent(ST_STOPPED, ACT_TLF), ent(ST_ACK_SENT, ACT_NONE)},
        // opened
        '{NOPE, ent(ST_STARTING, ACT_TLD), ent(ST_OPENED, ACT_NONE),
          ent(ST_CLOSING, ACT_TLD | ACT_IRC | ACT_STR), NOPE, NOPE,
          ent(ST_ACK_SENT, ACT_TLD | ACT_SCR | ACT_SCA),
          ent(ST_REQ_SENT, ACT_TLD | ACT_SCR | ACT_SCN),
          ent(ST_REQ_SENT, ACT_TLD | ACT_SCR), ent(ST_REQ_SENT, ACT_TLD | ACT_SCR),
          ent(ST_STOPPING, ACT_TLD | ACT_ZRC | ACT_STA),
          ent(ST_REQ_SENT, ACT_TLD | ACT_SCR),
          ent(ST_OPENED, ACT_SCJ), ent(ST_OPENED, ACT_NONE),
          ent(ST_STOPPING, ACT_TLD | ACT_IRC | ACT_STR), ent(ST_OPENED, ACT_SER)}
    };

endpackage

@@ design/ppp_neg_lookup.sv @@
// Transition lookup: current state and event to next state, actions and illegal flag.
module ppp_neg_lookup (
    input  ppp_neg_pkg::state_t  cur_state,
    input  ppp_neg_pkg::event_t  ev_in,
    input  logic                 layer_kind,
    output ppp_neg_pkg::lookup_t result
);
    import ppp_neg_pkg::*;

    state_t st;
    event_t ev;
    entry_t e;

    always_comb begin
        // a state code outside the table is treated as initial
        st = (cur_state > ST_OPENED) ? ST_INITIAL : cur_state;
        // link layer: starting takes every event as up
        ev = (st == ST_STARTING && layer_kind == LAYER_LCP) ? EV_UP : ev_in;
        e  = FSM_TABLE[st][ev];

        priority if (st == ST_REQ_SENT && layer_kind == LAYER_NCP && ev == EV_UP) begin
            // network layer ignores up while a request is out
            result.next_state  = ST_REQ_SENT;
            result.action_mask = ACT_NONE;
            result.illegal     = 1'b0;
        end else if (!e.legal) begin
            result.next_state  = st;
            result.action_mask = ACT_NONE;
            result.illegal     = 1'b1;
        end else begin
            result.next_state  = e.next_state;
            result.action_mask = e.actions;
            result.illegal     = 1'b0;
        end
    end

endmodule

@@ design/ppp_option_negotiation_fsm.sv @@
// Top level of the PPP option negotiation automaton with stream ports.
// One event item is accepted per clock cycle unless a waiting result is not taken, and its
// result appears on the master side in the next cycle; the rate is set by the state
// register, which is updated through the table lookup in the same cycle the event is taken.
// The input side stays ready while a result waits, as long as the result is taken in that
// cycle. layer_kind (cfg_wdata) selects link (0) or network (1) control behavior, and the user
// must see that it is written only while no item is in flight; the block does not enforce it.
module ppp_option_negotiation_fsm (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // layer_kind
    // event items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [3:0] event_code, [7:4] zero
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // [3:0] next_state, [16:4] action_mask, [23:17] zero
    output logic        m_tuser         // illegal_event
);
    import ppp_neg_pkg::*;

    logic    layer_reg;
    state_t  state_reg;
    lookup_t out_reg;
    logic    out_valid_reg;
    lookup_t res;
    logic    s_accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    ppp_neg_lookup u_lookup (
        .cur_state  (state_reg),
        .ev_in      (event_t'(s_tdata[3:0])),
        .layer_kind (layer_reg),
        .result     (res)
    );

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_reg <= LAYER_LCP;
        end else if (cfg_we) begin
            layer_reg <= cfg_wdata;
        end
    end

    // state register and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INITIAL;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg     <= res.next_state;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.action_mask, out_reg.next_state};
    assign m_tuser  = out_reg.illegal;

    // state always tracks the last reported next state
    a_state_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == out_reg.next_state)
        else $error("state register differs from reported next state");

    // an illegal event carries no actions
    a_illegal_no_act: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.illegal |-> out_reg.action_mask == ACT_NONE)
        else $error("illegal event reported with actions");

    // an accepted item always produces a result
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    // the state never leaves the table range
    a_state_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg <= ST_OPENED)
        else $error("state register out of range");

endmodule
